>>> rtl/ics_pkg.sv
// ----------------------------------------------------------------------------
// ics_pkg
// Shared types and constants of the inversion counter with position swaps:
// controller states, read and write selects, command and status groups.
// ----------------------------------------------------------------------------
package ics_pkg;

    // fixed field widths of the item and result channels
    localparam int ITEM_WIDTH = 16;
    localparam int POS_WIDTH  = 10;
    localparam int INV_WIDTH  = 19;

    // operation codes
    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_SWAP   = 1'b1;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_READ_LO,
        ST_READ_HI,
        ST_SCAN,
        ST_FIX,
        ST_WRITE_LO,
        ST_WRITE_HI,
        ST_WRITE_APPEND,
        ST_RESULT
    } state_t;

    // what a memory read fetches
    typedef enum logic [1:0] {
        RD_NONE,
        RD_LO,
        RD_HI,
        RD_SCAN
    } rd_sel_t;

    // what a memory write stores
    typedef enum logic [1:0] {
        WR_NONE,
        WR_LO,
        WR_HI,
        WR_APPEND
    } wr_sel_t;

    // controller to datapath
    typedef struct packed {
        logic    capture;
        rd_sel_t rd_sel;
        logic    ptr_inc;
        wr_sel_t wr_sel;
        logic    fix;
        logic    result_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_swap;
        logic bad;
        logic same_pos;
        logic scan_done;
        logic out_free;
    } sts_t;

endpackage

>>> rtl/ics_ctrl.sv
// ----------------------------------------------------------------------------
// ics_ctrl
// Controller state machine: takes a beat, sequences the end reads, the scan,
// the total fix-up and the write-back, then hands the result to the output.
// ----------------------------------------------------------------------------
module ics_ctrl
    import ics_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next      = state_reg;
        s_ready         = 1'b0;
        cmd.capture     = 1'b0;
        cmd.rd_sel      = RD_NONE;
        cmd.ptr_inc     = 1'b0;
        cmd.wr_sel      = WR_NONE;
        cmd.fix         = 1'b0;
        cmd.result_load = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (sts.bad || sts.same_pos) begin
                    state_next = ST_RESULT;
                end else if (sts.is_swap) begin
                    state_next = ST_READ_LO;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_READ_LO: begin
                cmd.rd_sel = RD_LO;
                state_next = ST_READ_HI;
            end
            ST_READ_HI: begin
                cmd.rd_sel = RD_HI;
                state_next = ST_SCAN;
            end
            // one element read per cycle; the last one is counted on exit
            ST_SCAN: begin
                if (!sts.scan_done) begin
                    cmd.rd_sel  = RD_SCAN;
                    cmd.ptr_inc = 1'b1;
                end else if (sts.is_swap) begin
                    state_next = ST_FIX;
                end else begin
                    state_next = ST_WRITE_APPEND;
                end
            end
            ST_FIX: begin
                cmd.fix    = 1'b1;
                state_next = ST_WRITE_LO;
            end
            ST_WRITE_LO: begin
                cmd.wr_sel = WR_LO;
                state_next = ST_WRITE_HI;
            end
            ST_WRITE_HI: begin
                cmd.wr_sel = WR_HI;
                state_next = ST_RESULT;
            end
            ST_WRITE_APPEND: begin
                cmd.wr_sel = WR_APPEND;
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (sts.out_free) begin
                    cmd.result_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/ics_dp.sv
// ----------------------------------------------------------------------------
// ics_dp
// Datapath: value memory, fill count, scan pointer, inversion total and the
// output register of the result channel.
// ----------------------------------------------------------------------------
module ics_dp
    import ics_pkg::*;
#(
    parameter int MAX_LEN     = 1024,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_op,
    input  logic [ITEM_WIDTH-1:0] s_item_value,
    input  logic [POS_WIDTH-1:0]  s_first_position,
    input  logic [POS_WIDTH-1:0]  s_second_position,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [INV_WIDTH-1:0]  m_inversions,
    output logic                  m_bad_request,
    input  cmd_t                  cmd,
    output sts_t                  sts
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int PW = (CW > POS_WIDTH) ? CW : POS_WIDTH + 1;
    localparam int TW = (2 * CW > INV_WIDTH) ? 2 * CW : INV_WIDTH;
    localparam int XW = (VALUE_WIDTH > ITEM_WIDTH) ? VALUE_WIDTH : ITEM_WIDTH;
    localparam logic [CW-1:0] FULL = CW'(MAX_LEN);

    logic [VALUE_WIDTH-1:0] mem [MAX_LEN];

    logic                   op_reg;
    logic                   bad_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [PW-1:0]          pos_a_reg;
    logic [PW-1:0]          pos_b_reg;
    logic [PW-1:0]          lo_reg;
    logic [PW-1:0]          hi_reg;
    logic [PW-1:0]          ptr_reg;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic [TW-1:0]          total_reg;
    logic [TW-1:0]          total_next;
    logic [VALUE_WIDTH-1:0] vl_reg;
    logic [VALUE_WIDTH-1:0] vh_reg;
    logic [VALUE_WIDTH-1:0] rdata_reg;
    rd_sel_t                rd_kind_reg;
    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic [INV_WIDTH-1:0]   m_inv_reg;
    logic                   m_bad_reg;

    logic [XW-1:0]          item_ext;
    logic [PW-1:0]          in_a;
    logic [PW-1:0]          in_b;
    logic [PW-1:0]          in_lo;
    logic [PW-1:0]          in_hi;
    logic [PW-1:0]          count_ext;
    logic [PW-1:0]          scan_end;
    logic [AW-1:0]          rd_addr;
    logic                   lt_l;
    logic                   gt_l;
    logic                   lt_h;
    logic                   gt_h;
    logic signed [2:0]      step;

    // incoming fields, zero extended
    assign item_ext = XW'(s_item_value);
    assign in_a     = PW'(s_first_position);
    assign in_b     = PW'(s_second_position);
    assign in_lo    = (in_a < in_b) ? in_a : in_b;
    assign in_hi    = (in_a < in_b) ? in_b : in_a;
    assign count_ext = PW'(count_reg);

    // item capture and scan pointer; refusal judged against the fill count at entry
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= s_op;
            bad_reg   <= (s_op == OP_SWAP)
                         ? (in_a >= count_ext) || (in_b >= count_ext)
                         : (count_reg == FULL);
            val_reg   <= item_ext[VALUE_WIDTH-1:0];
            pos_a_reg <= in_a;
            pos_b_reg <= in_b;
            lo_reg    <= in_lo;
            hi_reg    <= in_hi;
            ptr_reg   <= (s_op == OP_SWAP) ? in_lo + PW'(1) : '0;
        end else if (cmd.ptr_inc) begin
            ptr_reg   <= ptr_reg + PW'(1);
        end
    end

    // status for the controller
    assign scan_end      = (op_reg == OP_SWAP) ? hi_reg : count_ext;
    assign sts.is_swap   = (op_reg == OP_SWAP);
    assign sts.bad       = bad_reg;
    assign sts.same_pos  = (op_reg == OP_SWAP) && (pos_a_reg == pos_b_reg);
    assign sts.scan_done = (ptr_reg >= scan_end);
    assign sts.out_free  = !m_valid_reg || m_ready;

    // memory read port, data registered
    always_comb begin
        case (cmd.rd_sel)
            RD_LO:   rd_addr = lo_reg[AW-1:0];
            RD_HI:   rd_addr = hi_reg[AW-1:0];
            default: rd_addr = ptr_reg[AW-1:0];
        endcase
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_kind_reg <= RD_NONE;
        end else begin
            rd_kind_reg <= cmd.rd_sel;
        end
    end

    // end values of a swap
    always_ff @(posedge aclk) begin
        if (rd_kind_reg == RD_LO) begin
            vl_reg <= rdata_reg;
        end
        if (rd_kind_reg == RD_HI) begin
            vh_reg <= rdata_reg;
        end
    end

    // memory write port
    always_ff @(posedge aclk) begin
        case (cmd.wr_sel)
            WR_LO:     mem[lo_reg[AW-1:0]]    <= vh_reg;
            WR_HI:     mem[hi_reg[AW-1:0]]    <= vl_reg;
            WR_APPEND: mem[count_reg[AW-1:0]] <= val_reg;
            default: ;
        endcase
    end

    // per-element contribution to the total
    assign lt_l = (rdata_reg < vl_reg);
    assign gt_l = (rdata_reg > vl_reg);
    assign lt_h = (rdata_reg < vh_reg);
    assign gt_h = (rdata_reg > vh_reg);
    assign step = 3'(lt_h) + 3'(gt_l) - 3'(lt_l) - 3'(gt_h);

    // inversion total and fill count, wrapping arithmetic on the total
    always_comb begin
        total_next = total_reg;
        count_next = count_reg;
        if (rd_kind_reg == RD_SCAN) begin
            if (op_reg == OP_SWAP) begin
                total_next = total_reg + {{(TW-3){step[2]}}, step};
            end else if (rdata_reg > val_reg) begin
                total_next = total_reg + TW'(1);
            end
        end
        if (cmd.fix) begin
            if (vl_reg > vh_reg) begin
                total_next = total_reg - TW'(1);
            end else if (vl_reg < vh_reg) begin
                total_next = total_reg + TW'(1);
            end
        end
        if (cmd.wr_sel == WR_APPEND) begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
            count_reg <= '0;
        end else begin
            total_reg <= total_next;
            count_reg <= count_next;
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.result_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.result_load) begin
            m_inv_reg <= total_reg[INV_WIDTH-1:0];
            m_bad_reg <= sts.bad;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_inversions  = m_inv_reg;
    assign m_bad_request = m_bad_reg;

endmodule

>>> rtl/inversion_count_with_swaps_unit.sv
// ----------------------------------------------------------------------------
// inversion_count_with_swaps_unit
// Keeps an array of values and its inversion count; appends values and swaps
// positions, returning the updated count for every beat taken.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  s_       in         s_valid / s_ready  op, item_value, first/second_position
//  m_       out        m_valid / m_ready  inversions, bad_request
//
//  One item at a time. An append scans every stored value; a swap of
//  positions lo < hi reads both ends and scans the values strictly between
//  them; a refused item or a swap of a position with itself goes straight
//  to the result. The single read port of the value memory, one element per cycle, sets the scan.
//  Reset clears the fill count and total; the value memory is not cleared.
//  A result waiting on m_ready does not stop the next beat from being taken.
// ----------------------------------------------------------------------------
module inversion_count_with_swaps_unit
    import ics_pkg::*;
#(
    parameter int MAX_LEN     = 1024,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_op,
    input  logic [ITEM_WIDTH-1:0] s_item_value,
    input  logic [POS_WIDTH-1:0]  s_first_position,
    input  logic [POS_WIDTH-1:0]  s_second_position,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [INV_WIDTH-1:0]  m_inversions,
    output logic                  m_bad_request
);

    cmd_t cmd;
    sts_t sts;

    // sequencing
    ics_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // storage and arithmetic
    ics_dp #(
        .MAX_LEN     (MAX_LEN),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_op              (s_op),
        .s_item_value      (s_item_value),
        .s_first_position  (s_first_position),
        .s_second_position (s_second_position),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_inversions      (m_inversions),
        .m_bad_request     (m_bad_request),
        .cmd               (cmd),
        .sts               (sts)
    );

endmodule

>>> rtl/ics_checker.sv
// ----------------------------------------------------------------------------
// ics_checker
// Port-level checks of the inversion counter: results against taken beats,
// outstanding depth, refused items keep the count, result hold while stalled, reset.
// ----------------------------------------------------------------------------
module ics_checker
    import ics_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [INV_WIDTH-1:0] m_inversions,
    input logic                 m_bad_request
);

    logic [1:0]           pending_reg;
    logic [1:0]           pending_next;
    logic [INV_WIDTH-1:0] last_inv_reg;
    logic                 seen_reg;
    logic                 in_beat;
    logic                 out_beat;

    assign in_beat  = s_valid && s_ready;
    assign out_beat = m_valid && m_ready;

    // beats taken but not yet answered
    always_comb begin
        pending_next = pending_reg;
        if (in_beat && !out_beat) begin
            pending_next = pending_reg + 2'd1;
        end else if (!in_beat && out_beat) begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
            seen_reg    <= 1'b0;
        end else begin
            pending_reg <= pending_next;
            if (out_beat) begin
                seen_reg <= 1'b1;
            end
        end
    end

    // count of the last delivered result
    always_ff @(posedge aclk) begin
        if (out_beat) begin
            last_inv_reg <= m_inversions;
        end
    end

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_inversions) && $stable(m_bad_request))
        else $error("result changed while stalled");

    // no result without a beat taken
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pending_reg != 2'd0)
        else $error("result with no outstanding beat");

    // at most one in work and one waiting
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg != 2'd3)
        else $error("too many outstanding beats");

    // a refused item leaves the count as it was
    a_bad_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_request && seen_reg |-> m_inversions == last_inv_reg)
        else $error("refused item changed the count");

    // reset empties the result channel
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind inversion_count_with_swaps_unit ics_checker u_ics_checker (.*);
